[hw/rtl/lstl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstl_pkg
// Shared types and constants of the least-squares trend line block: the
// command and status records between controller and datapath, the controller
// states and the fixed result widths.
// ----------------------------------------------------------------------------
package lstl_pkg;

  // Width of the arithmetic word used by the fit computation.
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned STEP_W  = $clog2(WORD_W);
  localparam int unsigned SLOPE_W = 40;
  localparam int unsigned ICPT_W  = 48;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SUB,
    OP_DIV
  } op_e;

  typedef enum logic [3:0] {
    SRC_N,
    SRC_SX,
    SRC_SX2,
    SRC_SY,
    SRC_SXY,
    SRC_SCALE,
    SRC_T0,
    SRC_T1,
    SRC_DEN,
    SRC_SLOPE
  } src_e;

  typedef enum logic [2:0] {
    DST_T0,
    DST_T1,
    DST_DEN,
    DST_SLOPE,
    DST_ICPT
  } dst_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_DEN_A,
    ST_DEN_B,
    ST_DEN,
    ST_CHECK,
    ST_NUM_A,
    ST_NUM_B,
    ST_NUM,
    ST_NUM_SCALE,
    ST_SLOPE,
    ST_ICPT_A,
    ST_ICPT_B,
    ST_ICPT_SUB,
    ST_ICPT,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic take;       // accept one sample into the accumulators
    logic start;      // launch one arithmetic operation
    op_e  op;
    src_e src_a;
    src_e src_b;
    dst_e dst;
    logic check;      // latch the fit validity
    logic clear_fit;  // zero slope and intercept
    logic clear;      // clear sums, count and drop flag
  } cmd_t;

  typedef struct packed {
    logic op_done;
    logic fit_ok;
  } status_t;

endpackage

[hw/rtl/lstl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstl_ctrl
// Sequencer of the trend line block. Accepts samples while idle and, after
// the final sample of a series, steps the datapath through the fit.
// ----------------------------------------------------------------------------
module lstl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             last_i,
  input  lstl_pkg::status_t status_i,
  output lstl_pkg::cmd_t   cmd_o,
  output logic             busy_o,
  output logic             done_o
);
  import lstl_pkg::*;

  state_e state_q, state_d, next_op;
  logic   issued_q, issued_d;
  logic   is_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    issued_d = issued_q;
    next_op  = state_q;
    is_op    = 1'b0;
    busy_o   = (state_q != ST_IDLE);
    done_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        cmd_o.take = start_i;
        if (start_i && last_i) begin
          state_d = ST_DRAIN1;
        end
      end
      ST_DRAIN1: begin
        cmd_o.clear_fit = 1'b1;
        state_d = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_d = ST_DEN_A;
      end
      ST_DEN_A: begin
        is_op = 1'b1; cmd_o.op = OP_MUL; cmd_o.src_a = SRC_N; cmd_o.src_b = SRC_SX2;
        cmd_o.dst = DST_T0; next_op = ST_DEN_B;
      end
      ST_DEN_B: begin
        is_op = 1'b1; cmd_o.op = OP_MUL; cmd_o.src_a = SRC_SX; cmd_o.src_b = SRC_SX;
        cmd_o.dst = DST_T1; next_op = ST_DEN;
      end
      ST_DEN: begin
        is_op = 1'b1; cmd_o.op = OP_SUB; cmd_o.src_a = SRC_T0; cmd_o.src_b = SRC_T1;
        cmd_o.dst = DST_DEN; next_op = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d = status_i.fit_ok ? ST_NUM_A : ST_RESULT;
      end
      ST_NUM_A: begin
        is_op = 1'b1; cmd_o.op = OP_MUL; cmd_o.src_a = SRC_N; cmd_o.src_b = SRC_SXY;
        cmd_o.dst = DST_T0; next_op = ST_NUM_B;
      end
      ST_NUM_B: begin
        is_op = 1'b1; cmd_o.op = OP_MUL; cmd_o.src_a = SRC_SX; cmd_o.src_b = SRC_SY;
        cmd_o.dst = DST_T1; next_op = ST_NUM;
      end
      ST_NUM: begin
        is_op = 1'b1; cmd_o.op = OP_SUB; cmd_o.src_a = SRC_T0; cmd_o.src_b = SRC_T1;
        cmd_o.dst = DST_T0; next_op = ST_NUM_SCALE;
      end
      ST_NUM_SCALE: begin
        is_op = 1'b1; cmd_o.op = OP_MUL; cmd_o.src_a = SRC_T0; cmd_o.src_b = SRC_SCALE;
        cmd_o.dst = DST_T0; next_op = ST_SLOPE;
      end
      ST_SLOPE: begin
        is_op = 1'b1; cmd_o.op = OP_DIV; cmd_o.src_a = SRC_T0; cmd_o.src_b = SRC_DEN;
        cmd_o.dst = DST_SLOPE; next_op = ST_ICPT_A;
      end
      ST_ICPT_A: begin
        is_op = 1'b1; cmd_o.op = OP_MUL; cmd_o.src_a = SRC_SY; cmd_o.src_b = SRC_SCALE;
        cmd_o.dst = DST_T0; next_op = ST_ICPT_B;
      end
      ST_ICPT_B: begin
        is_op = 1'b1; cmd_o.op = OP_MUL; cmd_o.src_a = SRC_SLOPE; cmd_o.src_b = SRC_SX;
        cmd_o.dst = DST_T1; next_op = ST_ICPT_SUB;
      end
      ST_ICPT_SUB: begin
        is_op = 1'b1; cmd_o.op = OP_SUB; cmd_o.src_a = SRC_T0; cmd_o.src_b = SRC_T1;
        cmd_o.dst = DST_T0; next_op = ST_ICPT;
      end
      ST_ICPT: begin
        is_op = 1'b1; cmd_o.op = OP_DIV; cmd_o.src_a = SRC_T0; cmd_o.src_b = SRC_N;
        cmd_o.dst = DST_ICPT; next_op = ST_RESULT;
      end
      ST_RESULT: begin
        done_o      = 1'b1;
        cmd_o.clear = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Each operation is launched once, then the state waits for completion.
    if (is_op) begin
      if (!issued_q) begin
        cmd_o.start = 1'b1;
        issued_d    = 1'b1;
      end else if (status_i.op_done) begin
        issued_d = 1'b0;
        state_d  = next_op;
      end
    end
  end

endmodule

[hw/rtl/lstl_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstl_dp
// Datapath of the trend line block: a pipelined accumulator for the running
// sums and a 64-bit saturating unit with a bit-serial multiply and divide, a
// combinational subtract and a small set of work registers.
// ----------------------------------------------------------------------------
module lstl_dp #(
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lstl_pkg::cmd_t                 cmd_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output lstl_pkg::status_t              status_o,
  output logic signed [lstl_pkg::SLOPE_W-1:0] slope_o,
  output logic signed [lstl_pkg::ICPT_W-1:0]  intercept_o,
  output logic                           fit_valid_o,
  output logic                           samples_dropped_o,
  output logic [lstl_pkg::COUNT_W-1:0]   sample_count_o
);
  import lstl_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned X_W   = $clog2(MAX_POINTS);
  localparam int unsigned SX_W  = 2 * X_W;
  localparam int unsigned SX2_W = 3 * X_W;
  localparam int unsigned SY_W  = SAMPLE_WIDTH + CNT_W;
  localparam int unsigned SXY_W = SAMPLE_WIDTH + 2 * X_W;
  localparam int unsigned PXY_W = SAMPLE_WIDTH + X_W;

  localparam logic signed [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] SCALE = WORD_W'(1) << FRAC_BITS;

  function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] v);
    return v[WORD_W-1] ? (WORD_W'(0) - $unsigned(v)) : $unsigned(v);
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_to(input logic signed [WORD_W-1:0] v,
                                                      input int unsigned w);
    logic signed [WORD_W-1:0] hi;
    logic signed [WORD_W-1:0] lo;
    hi = (WORD_W'(1) << (w - 1)) - WORD_W'(1);
    lo = -hi - WORD_W'(1);
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Accumulation: sample register, product register, then the sums.
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]               count_q;
  logic                           dropped_q;
  logic [SX_W-1:0]                sx_q;
  logic [SX2_W-1:0]               sx2_q;
  logic signed [SY_W-1:0]         sy_q;
  logic signed [SXY_W-1:0]        sxy_q;
  logic                           s1_en_q, s2_en_q;
  logic [X_W-1:0]                 x1_q, x2_q;
  logic signed [SAMPLE_WIDTH-1:0] y1_q, y2_q;
  logic [2*X_W-1:0]               pxx_q, pxx_d;
  logic signed [PXY_W-1:0]        pxy_q;
  logic signed [X_W:0]            x1_s;
  logic signed [SAMPLE_WIDTH+X_W:0] pxy_full;
  logic                           room;

  assign room     = (count_q < CNT_W'(MAX_POINTS));
  assign x1_s     = $signed({1'b0, x1_q});
  assign pxy_full = x1_s * y1_q;
  assign pxx_d    = x1_q * x1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      sx_q      <= '0;
      sx2_q     <= '0;
      sy_q      <= '0;
      sxy_q     <= '0;
      s1_en_q   <= 1'b0;
      s2_en_q   <= 1'b0;
    end else begin
      s1_en_q <= cmd_i.take && room;
      s2_en_q <= s1_en_q;
      if (cmd_i.clear) begin
        count_q   <= '0;
        dropped_q <= 1'b0;
        sx_q      <= '0;
        sx2_q     <= '0;
        sy_q      <= '0;
        sxy_q     <= '0;
      end else begin
        if (cmd_i.take) begin
          if (room) begin
            count_q <= count_q + CNT_W'(1);
          end else begin
            dropped_q <= 1'b1;
          end
        end
        if (s2_en_q) begin
          sx_q  <= sx_q + SX_W'(x2_q);
          sx2_q <= sx2_q + SX2_W'(pxx_q);
          sy_q  <= sy_q + SY_W'(y2_q);
          sxy_q <= sxy_q + SXY_W'(pxy_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q  <= count_q[X_W-1:0];
    y1_q  <= sample_i;
    x2_q  <= x1_q;
    y2_q  <= y1_q;
    pxx_q <= pxx_d;
    pxy_q <= pxy_full[PXY_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Arithmetic unit and work registers.
  // --------------------------------------------------------------------------
  logic signed [WORD_W-1:0] t0_q, t1_q, den_q, slope_q;
  logic signed [ICPT_W-1:0] icpt_q;
  logic                     fit_valid_q;
  logic signed [WORD_W-1:0] opa, opb;

  always_comb begin
    case (cmd_i.src_a)
      SRC_N:     opa = WORD_W'(count_q);
      SRC_SX:    opa = WORD_W'(sx_q);
      SRC_SX2:   opa = WORD_W'(sx2_q);
      SRC_SY:    opa = WORD_W'(sy_q);
      SRC_SXY:   opa = WORD_W'(sxy_q);
      SRC_SCALE: opa = SCALE;
      SRC_T0:    opa = t0_q;
      SRC_T1:    opa = t1_q;
      SRC_DEN:   opa = den_q;
      SRC_SLOPE: opa = slope_q;
      default:   opa = '0;
    endcase
    case (cmd_i.src_b)
      SRC_N:     opb = WORD_W'(count_q);
      SRC_SX:    opb = WORD_W'(sx_q);
      SRC_SX2:   opb = WORD_W'(sx2_q);
      SRC_SY:    opb = WORD_W'(sy_q);
      SRC_SXY:   opb = WORD_W'(sxy_q);
      SRC_SCALE: opb = SCALE;
      SRC_T0:    opb = t0_q;
      SRC_T1:    opb = t1_q;
      SRC_DEN:   opb = den_q;
      SRC_SLOPE: opb = slope_q;
      default:   opb = '0;
    endcase
  end

  logic              run_q, fin_q, done_q;
  logic [STEP_W-1:0] step_q;
  op_e               op_q;
  dst_e              dst_q;
  logic [WORD_W-1:0] ma_q, mb_q, work_q;
  logic              ovf_q, neg_q;

  logic [WORD_W:0]   mul_sum, div_sh, div_diff;
  logic              div_ge;
  logic [WORD_W-1:0] div_rem;
  logic [WORD_W:0]   sub_diff;
  logic signed [WORD_W-1:0] sub_val, fin_val, wr_val;
  logic [WORD_W-1:0] fin_mag, fin_signed;
  logic              wr_en;
  dst_e              wr_dst;
  logic              launch;

  // The multiplier sums partial products from the top bit of the multiplier
  // down; once the running value reaches 2^63 the product is known to
  // saturate, so only its lower bits are kept.
  assign mul_sum  = {1'b0, work_q[WORD_W-2:0], 1'b0}
                  + (mb_q[WORD_W-1] ? {1'b0, ma_q} : (WORD_W+1)'(0));
  assign div_sh   = {work_q, mb_q[WORD_W-1]};
  assign div_diff = div_sh - {1'b0, ma_q};
  assign div_ge   = (div_sh >= {1'b0, ma_q});
  assign div_rem  = div_ge ? div_diff[WORD_W-1:0] : div_sh[WORD_W-1:0];

  assign sub_diff = {opa[WORD_W-1], opa} - {opb[WORD_W-1], opb};
  assign sub_val  = (sub_diff[WORD_W] != sub_diff[WORD_W-1]) ?
                    (sub_diff[WORD_W] ? W_MIN : W_MAX) : $signed(sub_diff[WORD_W-1:0]);

  always_comb begin
    case (op_q)
      OP_MUL:  fin_mag = {1'b0, work_q[WORD_W-2:0]};
      default: fin_mag = mb_q;
    endcase
    fin_signed = neg_q ? (WORD_W'(0) - fin_mag) : fin_mag;
    if (op_q == OP_MUL && ovf_q) begin
      fin_val = neg_q ? W_MIN : W_MAX;
    end else begin
      fin_val = $signed(fin_signed);
    end
  end

  assign launch = cmd_i.start && (cmd_i.op != OP_SUB);
  assign wr_en  = (cmd_i.start && cmd_i.op == OP_SUB) || fin_q;
  assign wr_dst = fin_q ? dst_q : cmd_i.dst;
  assign wr_val = fin_q ? fin_val : sub_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= wr_en;
      fin_q  <= run_q && (step_q == '0);
      if (launch) begin
        run_q <= 1'b1;
      end else if (run_q && step_q == '0) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      op_q   <= cmd_i.op;
      dst_q  <= cmd_i.dst;
      step_q <= STEP_W'(WORD_W - 1);
      work_q <= '0;
      ovf_q  <= 1'b0;
      neg_q  <= opa[WORD_W-1] ^ opb[WORD_W-1];
      // The divider shifts the dividend out of mb and the quotient into it.
      if (cmd_i.op == OP_DIV) begin
        mb_q <= mag(opa);
        ma_q <= mag(opb);
      end else begin
        ma_q <= mag(opa);
        mb_q <= mag(opb);
      end
    end else if (run_q) begin
      step_q <= step_q - STEP_W'(1);
      if (op_q == OP_MUL) begin
        work_q <= {1'b0, mul_sum[WORD_W-2:0]};
        ovf_q  <= ovf_q | mul_sum[WORD_W] | mul_sum[WORD_W-1];
        mb_q   <= {mb_q[WORD_W-2:0], 1'b0};
      end else begin
        work_q <= div_rem;
        mb_q   <= {mb_q[WORD_W-2:0], div_ge};
      end
    end
  end

  logic signed [WORD_W-1:0] icpt_sat;
  assign icpt_sat = sat_to(wr_val, ICPT_W);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_fit) begin
      slope_q <= '0;
      icpt_q  <= '0;
    end else if (wr_en) begin
      case (wr_dst)
        DST_T0:    t0_q    <= wr_val;
        DST_T1:    t1_q    <= wr_val;
        DST_DEN:   den_q   <= wr_val;
        DST_SLOPE: slope_q <= sat_to(wr_val, SLOPE_W);
        DST_ICPT:  icpt_q  <= icpt_sat[ICPT_W-1:0];
        default:   t0_q    <= wr_val;
      endcase
    end
    if (cmd_i.check) begin
      fit_valid_q <= status_o.fit_ok;
    end
  end

  logic [WORD_W-1:0] count_wide;
  assign count_wide = WORD_W'(count_q);

  assign status_o.op_done = done_q;
  assign status_o.fit_ok  = (count_q >= CNT_W'(2)) && (den_q > $signed(WORD_W'(0)));

  assign slope_o           = slope_q[SLOPE_W-1:0];
  assign intercept_o       = icpt_q;
  assign fit_valid_o       = fit_valid_q;
  assign samples_dropped_o = dropped_q;
  assign sample_count_o    = count_wide[COUNT_W-1:0];

endmodule

[hw/rtl/least_squares_trend_line_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_squares_trend_line_top
// Least-squares trend line over a stream of samples indexed 0, 1, 2, ...
// ----------------------------------------------------------------------------
// A sample is taken at every clock edge where start is high and busy is low,
// so a series streams in at one sample per cycle. The sample marked last
// raises busy on the next cycle; the fit then runs on one bit-serial 64-bit
// multiply/divide unit (64 steps per operation, seven multiplies and two
// divisions), and done_o pulses for a single cycle when the fit is done, or
// right after the denominator check when there are fewer than two samples.
// The receiver cannot hold the result off: it must capture slope_o,
// intercept_o and the flags in the cycle done_o is high.
// The sums are cleared with the result, and start is honored again from the
// cycle after done_o.
module least_squares_trend_line_top #(
  parameter int unsigned MAX_POINTS   = 1024,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           last_sample_i,
  output logic                           done_o,
  output logic signed [lstl_pkg::SLOPE_W-1:0] slope_o,
  output logic signed [lstl_pkg::ICPT_W-1:0]  intercept_o,
  output logic                           fit_valid_o,
  output logic                           samples_dropped_o,
  output logic [lstl_pkg::COUNT_W-1:0]   sample_count_o
);
  import lstl_pkg::*;

  cmd_t    cmd;
  status_t status;

  lstl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .last_i   (last_sample_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  lstl_dp #(
    .MAX_POINTS   (MAX_POINTS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sample_i          (sample_i),
    .status_o          (status),
    .slope_o           (slope_o),
    .intercept_o       (intercept_o),
    .fit_valid_o       (fit_valid_o),
    .samples_dropped_o (samples_dropped_o),
    .sample_count_o    (sample_count_o)
  );

endmodule

[hw/rtl/lstl_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstl_chk
// Port-level checks of the trend line block, bound to its top level.
// ----------------------------------------------------------------------------
module lstl_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          last_sample_i,
  input logic                          done_o,
  input logic                          fit_valid_o,
  input logic [lstl_pkg::SLOPE_W-1:0]  slope_o,
  input logic [lstl_pkg::ICPT_W-1:0]   intercept_o
);

  // A result only appears while a fit is in progress.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // The final request of a series starts the fit on the next cycle.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_sample_i) |=> busy)
    else $error("busy not raised after final sample");

  // The block is ready for the next series right after a result.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy held after result");

  // An invalid fit reports zero slope and intercept.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !fit_valid_o) |-> (slope_o == '0 && intercept_o == '0))
    else $error("nonzero fit on invalid result");

endmodule

bind least_squares_trend_line_top lstl_chk u_lstl_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .last_sample_i (last_sample_i),
  .done_o        (done_o),
  .fit_valid_o   (fit_valid_o),
  .slope_o       (slope_o),
  .intercept_o   (intercept_o)
);

[sim/least_squares_trend_line_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_squares_trend_line_top_tb
// Streams series of samples into the trend line block and checks every fit.
// A queue of sample requests feeds a clocked driver that sends in bursts with
// random gaps. A clocked monitor updates a cycle-free model of the running
// sums on each accepted request and compares every result, field by field,
// with the oldest predicted fit.
// ----------------------------------------------------------------------------
module least_squares_trend_line_top_tb;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned MAX_POINTS  = 1024;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned RANDOM_REQS = 250;
  // Both margins are generously longer than the longest fit, on purpose.
  localparam int unsigned TAIL_CYCLES  = 700;
  localparam int unsigned STALL_LIMIT  = 4000;

  localparam longint I64_MAX    = 64'sh7fff_ffff_ffff_ffff;
  localparam longint I64_MIN    = 64'sh8000_0000_0000_0000;
  localparam longint FRAC_SCALE = 64'sd1 <<< FRAC_W;

  typedef enum int unsigned {
    SHAPE_NOISE,
    SHAPE_RAMP,
    SHAPE_EXTREME,
    SHAPE_SMALL
  } series_shape_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                is_last;
  } sample_req_t;

  typedef struct {
    logic [lstl_pkg::SLOPE_W-1:0] slope;
    logic [lstl_pkg::ICPT_W-1:0]  intercept;
    logic                         valid;
    logic                         dropped;
    logic [lstl_pkg::COUNT_W-1:0] count;
  } trend_fit_t;

  logic                                clk_i         = 1'b0;
  logic                                rst_ni        = 1'b0;
  logic                                start         = 1'b0;
  logic                                busy;
  logic signed [SAMPLE_W-1:0]          sample_i      = '0;
  logic                                last_sample_i = 1'b0;
  logic                                done_o;
  logic signed [lstl_pkg::SLOPE_W-1:0] slope_o;
  logic signed [lstl_pkg::ICPT_W-1:0]  intercept_o;
  logic                                fit_valid_o;
  logic                                samples_dropped_o;
  logic [lstl_pkg::COUNT_W-1:0]        sample_count_o;

  sample_req_t pending_samples[$];
  trend_fit_t  expected_fits[$];

  // Running sums of the series in progress.
  int unsigned series_len     = 0;
  longint      sum_x          = 0;
  longint      sum_x2         = 0;
  longint      sum_y          = 0;
  longint      sum_xy         = 0;
  logic        series_dropped = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  logic        req_taken      = 1'b0;
  int unsigned burst_left     = 0;
  int unsigned gap_left       = 0;

  least_squares_trend_line_top #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_WIDTH(SAMPLE_W),
    .FRAC_BITS   (FRAC_W)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .sample_i         (sample_i),
    .last_sample_i    (last_sample_i),
    .done_o           (done_o),
    .slope_o          (slope_o),
    .intercept_o      (intercept_o),
    .fit_valid_o      (fit_valid_o),
    .samples_dropped_o(samples_dropped_o),
    .sample_count_o   (sample_count_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic longint clamp64(input logic signed [127:0] v);
    if (v > I64_MAX) return I64_MAX;
    if (v < I64_MIN) return I64_MIN;
    return v[63:0];
  endfunction

  function automatic longint sat_add(input longint a, input longint b);
    logic signed [127:0] s;
    s = a + b;
    return clamp64(s);
  endfunction

  function automatic longint sat_sub(input longint a, input longint b);
    logic signed [127:0] s;
    s = a - b;
    return clamp64(s);
  endfunction

  function automatic longint sat_mul(input longint a, input longint b);
    logic signed [127:0] p;
    p = a * b;
    return clamp64(p);
  endfunction

  function automatic longint clamp_width(input longint v, input int unsigned w);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Adds one accepted sample to the sums, or drops it once the series is full;
  // a final sample yields the predicted fit and starts a new series at index 0.
  task automatic accumulate_sample(input sample_req_t req);
    longint     x;
    longint     y;
    longint     n;
    longint     den;
    longint     num;
    longint     slope;
    longint     icpt;
    trend_fit_t fit;
    y = longint'($signed(req.value));
    if (series_len < MAX_POINTS) begin
      x = longint'(series_len);
      sum_x  = sat_add(sum_x, x);
      sum_x2 = sat_add(sum_x2, sat_mul(x, x));
      sum_y  = sat_add(sum_y, y);
      sum_xy = sat_add(sum_xy, sat_mul(x, y));
      series_len++;
    end else begin
      series_dropped = 1'b1;
    end
    if (req.is_last) begin
      n     = longint'(series_len);
      slope = 0;
      icpt  = 0;
      den   = sat_sub(sat_mul(n, sum_x2), sat_mul(sum_x, sum_x));
      fit.valid = (series_len >= 2) && (den > 0);
      if (fit.valid) begin
        num   = sat_sub(sat_mul(n, sum_xy), sat_mul(sum_x, sum_y));
        num   = sat_mul(num, FRAC_SCALE);
        slope = clamp_width(num / den, lstl_pkg::SLOPE_W);
        // The intercept is built from the slope after its saturation.
        icpt  = sat_sub(sat_mul(sum_y, FRAC_SCALE), sat_mul(slope, sum_x));
        icpt  = clamp_width(icpt / n, lstl_pkg::ICPT_W);
      end
      fit.slope     = slope[lstl_pkg::SLOPE_W-1:0];
      fit.intercept = icpt[lstl_pkg::ICPT_W-1:0];
      fit.dropped   = series_dropped;
      fit.count     = series_len[lstl_pkg::COUNT_W-1:0];
      expected_fits.push_back(fit);
      series_len     = 0;
      sum_x          = 0;
      sum_x2         = 0;
      sum_y          = 0;
      sum_xy         = 0;
      series_dropped = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
    sample_req_t req;
    req.value   = value;
    req.is_last = is_last;
    pending_samples.push_back(req);
  endtask

  task automatic add_series(input int unsigned len, input series_shape_e shape);
    int signed     base;
    int signed     step;
    int signed     level;
    logic [SAMPLE_W-1:0] value;
    base = int'($urandom_range(0, 65535)) - 32768;
    step = int'($urandom_range(0, 1024)) - 512;
    for (int unsigned i = 0; i < len; i++) begin
      case (shape)
        SHAPE_RAMP: begin
          level = base + step * int'(i) + int'($urandom_range(0, 200)) - 100;
          if (level > 32767) level = 32767;
          else if (level < -32768) level = -32768;
          value = level[SAMPLE_W-1:0];
        end
        SHAPE_EXTREME: value = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        SHAPE_SMALL:   value = 16'($urandom_range(0, 15) - 8);
        default:       value = 16'($urandom());
      endcase
      push_sample(value, i == len - 1);
    end
  endtask

  // Sender: bursts of requests separated by random gaps. A gap is only
  // opened after a request was taken, so a presented request is never pulled.
  always @(negedge clk_i) begin : driver
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (req_taken) begin
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
      if (gap_left != 0) begin
        gap_left--;
        start    <= 1'b0;
        sample_i <= SAMPLE_W'($urandom());
      end else if (pending_samples.size() != 0) begin
        start         <= 1'b1;
        sample_i      <= pending_samples[0].value;
        last_sample_i <= pending_samples[0].is_last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    trend_fit_t want;
    logic       progress;
    progress  = 1'b0;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        progress = 1'b1;
        if (expected_fits.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, actual %h %h",
                   $time, slope_o, intercept_o);
          mismatch_count++;
        end else begin
          want = expected_fits.pop_front();
          check_field("slope", want.slope, $unsigned(slope_o));
          check_field("intercept", want.intercept, $unsigned(intercept_o));
          check_field("fit_valid", want.valid, fit_valid_o);
          check_field("samples_dropped", want.dropped, samples_dropped_o);
          check_field("sample_count", want.count, sample_count_o);
        end
      end
      if (start && !busy) begin
        progress  = 1'b1;
        req_taken = 1'b1;
        accumulate_sample(pending_samples.pop_front());
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned random_reqs;
    int unsigned len;
    int unsigned pick;

    // Directed series: single sample, opposite two-sample extremes, a clean
    // ramp, a constant series of -1 and constant series at both rails.
    push_sample(16'h7fff, 1'b1);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7fff, 1'b1);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h8000, 1'b1);
    for (int unsigned i = 0; i < 4; i++) push_sample(16'(i * 256), i == 3);
    for (int unsigned i = 0; i < 3; i++) push_sample(16'hffff, i == 2);
    for (int unsigned i = 0; i < 5; i++) push_sample(16'h8000, i == 4);
    for (int unsigned i = 0; i < 5; i++) push_sample(16'h7fff, i == 4);

    // A series that fills the accumulators and then overruns them with the
    // largest possible trend; its last three requests are dropped.
    for (int unsigned i = 0; i < MAX_POINTS + 3; i++) begin
      push_sample((i < MAX_POINTS / 2) ? 16'h8000 : 16'h7fff, i == MAX_POINTS + 2);
    end

    random_reqs = 0;
    while (random_reqs < RANDOM_REQS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       len = 1;
        1:       len = 2;
        8:       len = $urandom_range(31, 120);
        9:       len = $urandom_range(2, 8);
        default: len = $urandom_range(3, 30);
      endcase
      add_series(len, series_shape_e'($urandom_range(0, 3)));
      random_reqs += len;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_samples.size() != 0 || expected_fits.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/lstl_pkg.sv
hw/rtl/lstl_ctrl.sv
hw/rtl/lstl_dp.sv
hw/rtl/least_squares_trend_line_top.sv
hw/rtl/lstl_chk.sv
sim/least_squares_trend_line_top_tb.sv
